FILE: sv/wildcard_glob_matcher_assert.svh
// assertion macros for the wildcard glob matcher
// used by the top level only, no other dependencies
`ifndef WILDCARD_GLOB_MATCHER_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define WGM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wgm check failed");

// antecedent implies consequent in the next cycle
`define WGM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wgm check failed");

`endif

FILE: sv/wgm_pkg.sv
// shared types, constants and helpers for the wildcard glob matcher
// no dependencies
package wgm_pkg;

   localparam int PATTERN_DEPTH_DEF = 256;
   localparam int NAME_DEPTH_DEF    = 256;

   localparam logic [7:0] CH_ANY      = 8'h3F;
   localparam logic [7:0] CH_STAR     = 8'h2A;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef enum logic [1:0] {
      FUNC_CLEAR_PAT   = 2'd0,
      FUNC_APPEND_PAT  = 2'd1,
      FUNC_APPEND_NAME = 2'd2,
      FUNC_EVALUATE    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic pat_clear;
      logic pat_append;
      logic name_append;
      logic name_clear;
      logic walk_init;
      logic walk_step;
      logic res_set;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic overflow;
      logic fin;
      logic out_free;
   } status_type;

   function automatic logic [7:0] lower_byte(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

FILE: sv/wildcard_glob_matcher.sv
// top level of the wildcard glob matcher: controller plus datapath
// depends on wgm_pkg, wgm_ctrl, wgm_datapath and wildcard_glob_matcher_assert.svh
//
//   channel  direction  ports
//   req      in         req_valid, req_stall, req_func, req_ch
//   rsp      out        rsp_valid, rsp_stall, rsp_matched, rsp_too_long
//
// clear and append beats are taken back to back.
// an evaluate beat runs the backtracking walk one compare step at a time; each step
// passes through ST_FETCH and ST_CMP, waiting on the registered read of both stores;
// the step count depends on the data, up to about name length times pattern length.
// with an overflow flagged an evaluate goes straight to ST_DONE without a walk.
// reset is synchronous; req_stall stays high from an evaluate until its result
// is loaded into the rsp register, which holds under rsp_stall.
`include "wildcard_glob_matcher_assert.svh"

module wildcard_glob_matcher
   import wgm_pkg::*;
#(
   parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF,
   parameter int NAME_DEPTH    = NAME_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [7:0] req_ch,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_matched,
   output logic       rsp_too_long
);

   cmd_type    cmd;
   status_type status;
   logic       eval_beat;

   wgm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wgm_datapath #(
      .PATTERN_DEPTH (PATTERN_DEPTH),
      .NAME_DEPTH    (NAME_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_ch       (req_ch),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_matched  (rsp_matched),
      .rsp_too_long (rsp_too_long)
   );

   assign eval_beat = req_valid && !req_stall && req_func == FUNC_EVALUATE;

   `WGM_ASSERT_SAME(a_long_no_match, clock, reset, rsp_valid && rsp_too_long, !rsp_matched)
   `WGM_ASSERT_NEXT(a_eval_busy, clock, reset, eval_beat, req_stall)
   `WGM_ASSERT_SAME(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

FILE: sv/wgm_datapath.sv
// datapath: pattern and name stores, lengths, match walk registers, result beat
// depends on wgm_pkg
module wgm_datapath
   import wgm_pkg::*;
#(
   parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF,
   parameter int NAME_DEPTH    = NAME_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  logic [7:0] req_ch,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output logic       rsp_matched,
   output logic       rsp_too_long
);

   localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int NAW = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
   localparam int PLW = $clog2(PATTERN_DEPTH + 1);
   localparam int NLW = $clog2(NAME_DEPTH + 1);
   localparam logic [PLW-1:0] PAT_FULL  = PLW'(PATTERN_DEPTH);
   localparam logic [NLW-1:0] NAME_FULL = NLW'(NAME_DEPTH);

   typedef enum logic [2:0] {
      STEP_ADVANCE,
      STEP_STAR,
      STEP_BACKTRACK,
      STEP_SKIP_STAR,
      STEP_FINISH
   } step_type;

   logic [7:0]     pat_mem [PATTERN_DEPTH];
   logic [7:0]     name_mem [NAME_DEPTH];
   logic [7:0]     pat_rd_ff;
   logic [7:0]     name_rd_ff;

   logic [PLW-1:0] plen_ff, plen_in;
   logic [NLW-1:0] nlen_ff, nlen_in;
   logic           povf_ff, povf_in;
   logic           novf_ff, novf_in;
   logic           pat_we;
   logic           name_we;

   logic [PLW-1:0] pi_ff, pi_in;
   logic [NLW-1:0] ni_ff, ni_in;
   logic [PLW-1:0] star_p_ff, star_p_in;
   logic [NLW-1:0] star_n_ff, star_n_in;
   logic           have_star_ff, have_star_in;
   logic           res_match_ff;
   logic           fin_match;
   step_type       step;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_matched_ff;
   logic           rsp_too_long_ff;

   logic           p_in;
   logic           n_in;
   logic           is_any;
   logic           is_star;
   logic           is_eq;

   // stores
   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[plen_ff[PAW-1:0]] <= req_ch;
      end
      pat_rd_ff <= pat_mem[pi_ff[PAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (name_we) begin
         name_mem[nlen_ff[NAW-1:0]] <= req_ch;
      end
      name_rd_ff <= name_mem[ni_ff[NAW-1:0]];
   end

   // lengths and overflow flags
   always_comb begin
      plen_in = plen_ff;
      nlen_in = nlen_ff;
      povf_in = povf_ff;
      novf_in = novf_ff;
      pat_we  = 1'b0;
      name_we = 1'b0;
      if (cmd.pat_clear) begin
         plen_in = '0;
         povf_in = 1'b0;
      end
      if (cmd.pat_append && req_ch != 8'd0) begin
         if (plen_ff < PAT_FULL) begin
            pat_we  = 1'b1;
            plen_in = plen_ff + PLW'(1);
         end else begin
            povf_in = 1'b1;
         end
      end
      if (cmd.name_append && req_ch != 8'd0) begin
         if (nlen_ff < NAME_FULL) begin
            name_we = 1'b1;
            nlen_in = nlen_ff + NLW'(1);
         end else begin
            novf_in = 1'b1;
         end
      end
      if (cmd.name_clear) begin
         nlen_in = '0;
         novf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0;
         nlen_ff <= '0;
         povf_ff <= 1'b0;
         novf_ff <= 1'b0;
      end else begin
         plen_ff <= plen_in;
         nlen_ff <= nlen_in;
         povf_ff <= povf_in;
         novf_ff <= novf_in;
      end
   end

   // one step of the star backtracking walk
   assign p_in    = pi_ff < plen_ff;
   assign n_in    = ni_ff < nlen_ff;
   assign is_any  = pat_rd_ff == CH_ANY;
   assign is_star = pat_rd_ff == CH_STAR;
   assign is_eq   = lower_byte(pat_rd_ff) == lower_byte(name_rd_ff);

   always_comb begin
      step      = STEP_FINISH;
      fin_match = 1'b0;
      if (n_in) begin
         if (p_in && (is_any || is_eq)) begin
            step = STEP_ADVANCE;
         end else if (p_in && is_star) begin
            step = STEP_STAR;
         end else if (have_star_ff) begin
            step = STEP_BACKTRACK;
         end
      end else begin
         if (p_in && is_star) begin
            step = STEP_SKIP_STAR;
         end else begin
            fin_match = !p_in;
         end
      end
   end

   always_comb begin
      pi_in        = pi_ff;
      ni_in        = ni_ff;
      star_p_in    = star_p_ff;
      star_n_in    = star_n_ff;
      have_star_in = have_star_ff;
      if (cmd.walk_init) begin
         pi_in        = '0;
         ni_in        = '0;
         star_p_in    = '0;
         star_n_in    = '0;
         have_star_in = 1'b0;
      end else if (cmd.walk_step) begin
         case (step)
            STEP_ADVANCE: begin
               pi_in = pi_ff + PLW'(1);
               ni_in = ni_ff + NLW'(1);
            end
            STEP_STAR: begin
               pi_in        = pi_ff + PLW'(1);
               star_p_in    = pi_ff + PLW'(1);
               star_n_in    = ni_ff;
               have_star_in = 1'b1;
            end
            STEP_BACKTRACK: begin
               star_n_in = star_n_ff + NLW'(1);
               pi_in     = star_p_ff;
               ni_in     = star_n_ff + NLW'(1);
            end
            STEP_SKIP_STAR: begin
               pi_in = pi_ff + PLW'(1);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      pi_ff        <= pi_in;
      ni_ff        <= ni_in;
      star_p_ff    <= star_p_in;
      star_n_ff    <= star_n_in;
      have_star_ff <= have_star_in;
      if (cmd.res_set) begin
         res_match_ff <= fin_match;
      end
   end

   // result beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_matched_ff  <= res_match_ff && !(povf_ff || novf_ff);
         rsp_too_long_ff <= povf_ff || novf_ff;
      end
   end

   assign status.overflow = povf_ff || novf_ff;
   assign status.fin      = step == STEP_FINISH;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_matched  = rsp_matched_ff;
   assign rsp_too_long = rsp_too_long_ff;

endmodule

FILE: sv/wgm_ctrl.sv
// controller state machine: decodes request beats and sequences the match walk
// depends on wgm_pkg
module wgm_ctrl
   import wgm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_func,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   func_type  func;

   assign func = func_type'(req_func);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (func)
                  FUNC_CLEAR_PAT:   cmd.pat_clear   = 1'b1;
                  FUNC_APPEND_PAT:  cmd.pat_append  = 1'b1;
                  FUNC_APPEND_NAME: cmd.name_append = 1'b1;
                  FUNC_EVALUATE: begin
                     if (status.overflow) begin
                        state_in = ST_DONE;
                     end else begin
                        cmd.walk_init = 1'b1;
                        state_in      = ST_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (status.fin) begin
               cmd.res_set = 1'b1;
               state_in    = ST_DONE;
            end else begin
               cmd.walk_step = 1'b1;
               state_in      = ST_FETCH;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.name_clear = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
